[hdl/rcl_pkg.sv]
package rcl_pkg;

	// fixed-point formats
	localparam int COEF_BITS  = 20;
	localparam int LIN_W      = 17;
	localparam int COEF_W     = 20;
	localparam int V_W        = 37;
	localparam int F_W        = 21;
	localparam int CRT_STAGES = 21;
	localparam int X_W        = 3 * CRT_STAGES;
	localparam int REM_W      = 48;
	localparam int SQ_W       = 42;
	localparam int BIG_W      = 264;

	// linear segment of f(): (9033*v + 160<<36 + den/2) / (1160<<16)
	localparam int LSEG_N_W   = 45;
	localparam int LSEG_M_W   = 29;
	localparam int LSEG_P_W   = 58;
	localparam int LSEG_Q_W   = 19;
	localparam int LSEG_SHIFT = 39;

	typedef logic [LIN_W-1:0]  lin_t;
	typedef lin_t              lin_tab_t [256];
	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [V_W-1:0]    v_t;
	typedef logic [F_W-1:0]    f_t;

	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	typedef struct packed {
		logic [14:0]        lightness;
		logic signed [15:0] green_red;
		logic signed [15:0] blue_yellow;
		logic               last_out;
	} lab_t;

	// sRGB to XYZ with the D65 white divided into each row
	localparam coef_t MIX [3][3] = '{
		'{20'd455036, 20'd394490, 20'd199065},
		'{20'd223004, 20'd749891, 20'd75681},
		'{20'd18620,  20'd114793, 20'd915235}
	};

	localparam v_t                    EPS_Q36     = 37'd608579686;
	localparam logic [13:0]           LSEG_GAIN   = 14'd9033;
	localparam logic [LSEG_N_W-1:0]   LSEG_OFFS   = 45'd10995154288640;
	localparam logic [LSEG_M_W-1:0]   LSEG_RECIP  = 29'd473927426;

	// Build the sRGB decode curve exactly: largest e with
	// 10761^12 * (2e-1)^5 <= (40c+561)^12 * 2^85 for codes above 10
	function automatic lin_tab_t build_lin_tab();
		lin_tab_t          tab;
		logic [BIG_W-1:0]  dpow;
		logic [BIG_W-1:0]  rhs;
		logic [BIG_W-1:0]  lhs;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       mid;
		int                c;
		int                k;
		dpow = BIG_W'(1);
		for (k = 0; k < 12; k++) begin
			dpow = dpow * BIG_W'(10761);
		end
		for (c = 0; c < 256; c++) begin
			if (c <= 10) begin
				tab[c] = LIN_W'((655360 * c + 16473) / 32946);
			end else begin
				rhs = BIG_W'(1);
				for (k = 0; k < 12; k++) begin
					rhs = rhs * BIG_W'(40 * c + 561);
				end
				rhs = rhs << 85;
				lo = 0;
				hi = 65536;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					lhs = dpow;
					for (k = 0; k < 5; k++) begin
						lhs = lhs * BIG_W'(2 * mid - 1);
					end
					if (lhs <= rhs) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				tab[c] = LIN_W'(lo);
			end
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

[hdl/rcl_pix_if.sv]
interface rcl_pix_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel;
	logic        last_pixel;

	modport source (output valid, output pixel, output last_pixel, input ready);
	modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

[hdl/rcl_lab_if.sv]
interface rcl_lab_if;
	logic               valid;
	logic               ready;
	logic [14:0]        lightness;
	logic signed [15:0] green_red;
	logic signed [15:0] blue_yellow;
	logic               last_out;

	modport source (output valid, output lightness, output green_red, output blue_yellow,
		output last_out, input ready);
	modport sink (input valid, input lightness, input green_red, input blue_yellow,
		input last_out, output ready);
endinterface

[hdl/rcl_linmix.sv]
module rcl_linmix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rcl_pkg::tag_t in_tag,
	input  logic [23:0]   pixel,
	output rcl_pkg::tag_t out_tag,
	output rcl_pkg::v_t   v [3]
);
	import rcl_pkg::*;

	tag_t tag_s1, tag_s2, tag_s3;
	lin_t lin_s1 [3];
	v_t   prod_s2 [3][3];
	v_t   v_s3 [3];

	// advance word tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// decode curve, matrix products, row sums
	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1[0] <= LIN_TAB[pixel[23:16]];
			lin_s1[1] <= LIN_TAB[pixel[15:8]];
			lin_s1[2] <= LIN_TAB[pixel[7:0]];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= V_W'(lin_s1[j]) * V_W'(MIX[i][j]);
				end
				v_s3[i] <= prod_s2[i][0] + prod_s2[i][1] + prod_s2[i][2];
			end
		end
	end

	assign out_tag = tag_s3;
	assign v = v_s3;
endmodule

[hdl/rcl_fcurve.sv]
module rcl_fcurve (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rcl_pkg::tag_t in_tag,
	input  rcl_pkg::v_t   v,
	output rcl_pkg::tag_t out_tag,
	output rcl_pkg::f_t   f
);
	import rcl_pkg::*;

	localparam int LQ_N = CRT_STAGES - 2;

	tag_t                  tag_s [CRT_STAGES];
	logic                  big_s [CRT_STAGES];
	logic [X_W-1:0]        x_s   [CRT_STAGES];
	logic [REM_W-1:0]      rem_s [CRT_STAGES];
	logic [F_W-1:0]        y_s   [CRT_STAGES];
	logic [SQ_W-1:0]       sq_s  [CRT_STAGES];
	logic [LSEG_N_W-1:0]   ln_s1;
	logic [LSEG_P_W-1:0]   lp_s2;
	logic [LSEG_Q_W-1:0]   lq_s  [LQ_N];

	// cube root, one bit of the root per stage
	for (genvar k = 0; k < CRT_STAGES; k++) begin : g_stage
		tag_t             tag_i;
		logic             big_i;
		logic [X_W-1:0]   x_i;
		logic [REM_W-1:0] rem_i;
		logic [F_W-1:0]   y_i;
		logic [SQ_W-1:0]  sq_i;
		logic [REM_W-1:0] remsh;
		logic [REM_W-1:0] trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign tag_i = in_tag;
			assign big_i = (v >= EPS_Q36);
			assign x_i   = {2'b00, v, 24'd0};
			assign rem_i = '0;
			assign y_i   = '0;
			assign sq_i  = '0;
		end else begin : g_next
			assign tag_i = tag_s[k-1];
			assign big_i = big_s[k-1];
			assign x_i   = x_s[k-1];
			assign rem_i = rem_s[k-1];
			assign y_i   = y_s[k-1];
			assign sq_i  = sq_s[k-1];
		end

		// try root bit one: (2y+1)^3 - 8y^3 = 12y^2 + 6y + 1
		assign remsh = {rem_i[REM_W-4:0], x_i[X_W-1:X_W-3]};
		assign trial = REM_W'({sq_i, 3'b000}) + REM_W'({sq_i, 2'b00})
			+ REM_W'({y_i, 2'b00}) + REM_W'({y_i, 1'b0}) + REM_W'(1);
		assign ge = (remsh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				big_s[k] <= big_i;
				x_s[k]   <= {x_i[X_W-4:0], 3'b000};
				y_s[k]   <= {y_i[F_W-2:0], ge};
				if (ge) begin
					rem_s[k] <= remsh - trial;
					sq_s[k]  <= SQ_W'({sq_i, 2'b00}) + SQ_W'({y_i, 2'b00}) + SQ_W'(1);
				end else begin
					rem_s[k] <= remsh;
					sq_s[k]  <= SQ_W'({sq_i, 2'b00});
				end
			end
		end
	end

	// linear segment: scale, multiply by reciprocal, then hold alongside the root
	always_ff @(posedge clk) begin
		if (en) begin
			ln_s1 <= LSEG_N_W'(LSEG_GAIN) * LSEG_N_W'(v[29:0]) + LSEG_OFFS;
			lp_s2 <= LSEG_P_W'(ln_s1[LSEG_N_W-1:16]) * LSEG_P_W'(LSEG_RECIP);
			lq_s[0] <= lp_s2[LSEG_P_W-1:LSEG_SHIFT];
			for (int j = 1; j < LQ_N; j++) begin
				lq_s[j] <= lq_s[j-1];
			end
		end
	end

	assign out_tag = tag_s[CRT_STAGES-1];
	assign f = big_s[CRT_STAGES-1] ? y_s[CRT_STAGES-1] : F_W'(lq_s[LQ_N-1]);
endmodule

[hdl/rcl_labout.sv]
module rcl_labout #(
	parameter int FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rcl_pkg::tag_t in_tag,
	input  rcl_pkg::f_t   f [3],
	output rcl_pkg::tag_t out_tag,
	output rcl_pkg::lab_t lab
);
	import rcl_pkg::*;

	localparam int          SH       = COEF_BITS - FRAC_BITS;
	localparam int          LMAX_RAW = 100 << FRAC_BITS;
	localparam logic [14:0] L_MAX    = (LMAX_RAW < 32767) ? 15'(LMAX_RAW) : 15'd32767;
	localparam logic [31:0] HALF     = 32'd1 << (SH - 1);

	tag_t               tag_s1, tag_s2;
	logic signed [31:0] l_s1, a_s1, b_s1;
	lab_t               lab_s2;
	logic [31:0]        l_r;
	logic [14:0]        l_sat;

	// round half away from zero, saturate to 16 bits
	function automatic logic [15:0] sat_ab(input logic signed [31:0] x);
		logic [31:0] mag;
		logic [31:0] r;
		mag = x[31] ? 32'(-x) : 32'(x);
		r = (mag + HALF) >> SH;
		if (x[31]) begin
			return (r >= 32'd32768) ? 16'h8000 : 16'(-r);
		end
		return (r > 32'd32767) ? 16'h7fff : r[15:0];
	endfunction

	// round and clamp lightness
	assign l_r = (32'(l_s1) + HALF) >> SH;
	assign l_sat = l_s1[31] ? 15'd0 : ((l_r > 32'(L_MAX)) ? L_MAX : l_r[14:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1 <= $signed(32'(f[1])) * 32'sd116 - 32'sd16777216;
			a_s1 <= ($signed(32'(f[0])) - $signed(32'(f[1]))) * 32'sd500;
			b_s1 <= ($signed(32'(f[1])) - $signed(32'(f[2]))) * 32'sd200;
			lab_s2.lightness   <= l_sat;
			lab_s2.green_red   <= sat_ab(a_s1);
			lab_s2.blue_yellow <= sat_ab(b_s1);
			lab_s2.last_out    <= tag_s1.last;
		end
	end

	assign out_tag = tag_s2;
	assign lab = lab_s2;
endmodule

[hdl/rgb_to_cielab_converter.sv]
// channel  dir  payload                                          handshake
// pix      in   pixel[23:0] (R 23:16, G 15:8, B 7:0), last_pixel  valid/ready
// lab      out  lightness[14:0], green_red, blue_yellow, last_out valid/ready
//
// One pixel per clock sustained while no stall holds the pipeline; from accept to lab.valid
// it runs through 3 decode/matrix, 21 cube-root bit stages, 2 scale/round, 1 output register.
// The cube-root bit stages set the depth; every stage is a trial sum, compare and subtract.
// arst_n clears all valid bits; the decode table is constant logic.
// A stall holds the whole pipeline; a skid word lets one more result drain
// into the output side, so pix.ready is a register output.
module rgb_to_cielab_converter #(
	parameter int FRAC_BITS = 8
) (
	input logic       clk,
	input logic       arst_n,
	rcl_pix_if.sink   pix,
	rcl_lab_if.source lab
);
	import rcl_pkg::*;

	localparam int          LMAX_RAW = 100 << FRAC_BITS;
	localparam logic [14:0] L_MAX    = (LMAX_RAW < 32767) ? 15'(LMAX_RAW) : 15'd32767;

	logic en;
	tag_t in_tag, mix_tag, fc_tag, fin_tag;
	tag_t fy_tag, fz_tag;
	v_t   v [3];
	f_t   f [3];
	lab_t fin;
	lab_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic fire_out;

	assign en        = !skid_valid_q;
	assign pix.ready = en;
	assign in_tag    = '{valid: pix.valid, last: pix.last_pixel};

	rcl_linmix u_linmix (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_tag(in_tag), .pixel(pix.pixel),
		.out_tag(mix_tag), .v(v)
	);

	rcl_fcurve u_fx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_tag(mix_tag), .v(v[0]), .out_tag(fc_tag), .f(f[0])
	);

	rcl_fcurve u_fy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_tag(mix_tag), .v(v[1]), .out_tag(fy_tag), .f(f[1])
	);

	rcl_fcurve u_fz (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_tag(mix_tag), .v(v[2]), .out_tag(fz_tag), .f(f[2])
	);

	rcl_labout #(.FRAC_BITS(FRAC_BITS)) u_labout (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_tag(fc_tag), .f(f),
		.out_tag(fin_tag), .lab(fin)
	);

	assign fire_out = out_valid_q && lab.ready;

	// output word and skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (fire_out || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= en && fin_tag.valid;
			end
		end else if (en && fin_tag.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_out || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : fin;
		end else if (en && fin_tag.valid) begin
			skid_q <= fin;
		end
	end

	assign lab.valid       = out_valid_q;
	assign lab.lightness   = out_q.lightness;
	assign lab.green_red   = out_q.green_red;
	assign lab.blue_yellow = out_q.blue_yellow;
	assign lab.last_out    = out_q.last_out;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without an output word");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !lab.ready))
		else $error("skid word filled while output was free");

	a_l_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.lightness <= L_MAX))
		else $error("lightness above its clamp");

	a_tag_align: assert property (@(posedge clk) disable iff (!arst_n)
		(fy_tag == fc_tag) && (fz_tag == fc_tag))
		else $error("cube-root lanes out of step");
endmodule

[dv/rgb_to_cielab_converter_tb.sv]
`timescale 1ns / 1ps

module rgb_to_cielab_converter_tb;
	import rcl_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int LATENCY   = 27;
	localparam int N_RANDOM  = 630;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [14:0]        lightness;
		logic signed [15:0] green_red;
		logic signed [15:0] blue_yellow;
		logic               last_out;
	} lab_word_t;

	logic clk;
	logic arst_n;

	rcl_pix_if pix ();
	rcl_lab_if lab ();

	rgb_to_cielab_converter #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix.sink),
		.lab    (lab.source)
	);

	// Linear-light decode table, built exactly with wide integers
	logic [16:0] decode_tab [256];

	function automatic logic [16:0] decode_entry(int c);
		logic [263:0] dpow;
		logic [263:0] rhs;
		logic [263:0] lhs;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		int           k;
		if (c <= 10) begin
			return 17'((655360 * c + 16473) / 32946);
		end
		dpow = 264'(1);
		rhs = 264'(1);
		for (k = 0; k < 12; k++) begin
			dpow = dpow * 264'(10761);
			rhs = rhs * 264'(40 * c + 561);
		end
		rhs = rhs << 85;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = dpow;
			for (k = 0; k < 5; k++) begin
				lhs = lhs * 264'(2 * mid - 1);
			end
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return 17'(lo);
	endfunction

	function automatic longint unsigned cbrt_floor(longint unsigned x);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 2097151;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * mid <= x) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo;
	endfunction

	// Map normalized value (36 fraction bits) to f() with 20 fraction bits
	function automatic longint lab_curve(longint unsigned v);
		longint unsigned num;
		longint unsigned den;
		if (v >= 64'd608579686) begin
			return longint'(cbrt_floor(v << 24));
		end
		den = 64'd1160 << 16;
		num = 64'd9033 * v + (64'd160 << 36);
		return longint'((num + den / 2) / den);
	endfunction

	function automatic longint round_half_away(longint x, int sh);
		longint unsigned half;
		half = 64'd1 << (sh - 1);
		if (x >= 0) begin
			return longint'((unsigned'(x) + half) >> sh);
		end
		return -longint'((unsigned'(-x) + half) >> sh);
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic lab_word_t convert_pixel(logic [23:0] px, logic last);
		longint unsigned lin [3];
		longint unsigned v;
		longint          f [3];
		longint          lval;
		longint          aval;
		longint          bval;
		longint          lmax;
		lab_word_t       w;
		int              sh;
		int              i;
		sh = COEF_BITS - FRAC_BITS;
		lin[0] = decode_tab[px[23:16]];
		lin[1] = decode_tab[px[15:8]];
		lin[2] = decode_tab[px[7:0]];
		for (i = 0; i < 3; i++) begin
			v = lin[0] * MIX[i][0] + lin[1] * MIX[i][1] + lin[2] * MIX[i][2];
			f[i] = lab_curve(v);
		end
		lmax = (64'sd100 << FRAC_BITS) < 32767 ? (64'sd100 << FRAC_BITS) : 32767;
		lval = clip(round_half_away(116 * f[1] - (64'sd16 << COEF_BITS), sh), 0, lmax);
		aval = clip(round_half_away(500 * (f[0] - f[1]), sh), -32768, 32767);
		bval = clip(round_half_away(200 * (f[1] - f[2]), sh), -32768, 32767);
		w.lightness = 15'(lval);
		w.green_red = 16'(aval);
		w.blue_yellow = 16'(bval);
		w.last_out = last;
		return w;
	endfunction

	class lab_scoreboard;
		lab_word_t pending [$];
		int        mismatches;

		function void note_pixel(logic [23:0] px, logic last);
			pending.insert(pending.size(), convert_pixel(px, last));
		endfunction

		function void check_word(lab_word_t got);
			lab_word_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected lab word %h", got);
				end
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("lab mismatch: want L=%0d a=%0d b=%0d last=%0b got L=%0d a=%0d b=%0d last=%0b",
						want.lightness, want.green_red, want.blue_yellow, want.last_out,
						got.lightness, got.green_red, got.blue_yellow, got.last_out);
				end
			end
		endfunction
	endclass

	lab_scoreboard sb;
	int            idle_cycles = 0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Send one pixel word and hold until accepted
	task automatic send_pixel(logic [23:0] px, logic last);
		int g;
		g = gap_len();
		// drop valid for the gap, if any
		if (g > 0) begin
			pix.valid <= 1'b0;
			repeat (g) begin
				@(posedge clk);
			end
		end
		pix.valid <= 1'b1;
		pix.pixel <= px;
		pix.last_pixel <= last;
		do begin
			@(posedge clk);
		end while (!pix.ready);
		sb.note_pixel(px, last);
	endtask

	// Toggle lab.ready with random stalls, in bursts and in quiet stretches
	initial begin
		int g;
		lab.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			lab.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) begin
				@(posedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				lab.ready <= 1'b0;
				repeat (g) begin
					@(posedge clk);
				end
			end
		end
	end

	// Check results and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (lab.valid && lab.ready) begin
				sb.check_word({lab.lightness, lab.green_red, lab.blue_yellow, lab.last_out});
			end
			if ((lab.valid && lab.ready) || (pix.valid && pix.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] edge_codes [6];
		int         i;
		int         r;
		logic [23:0] px;
		sb = new();
		for (i = 0; i < 256; i++) begin
			decode_tab[i] = decode_entry(i);
		end
		edge_codes = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.pixel = '0;
		pix.last_pixel = 1'b0;
		repeat (5) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: black, white, primaries, secondaries, grays, decode knee, dark kappa segment
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'hFF0000, 1'b0);
		send_pixel(24'h00FF00, 1'b0);
		send_pixel(24'h0000FF, 1'b1);
		send_pixel(24'hFFFF00, 1'b0);
		send_pixel(24'h00FFFF, 1'b0);
		send_pixel(24'hFF00FF, 1'b0);
		send_pixel(24'h0A0A0A, 1'b0);
		send_pixel(24'h0B0B0B, 1'b1);
		send_pixel(24'h010101, 1'b0);
		send_pixel(24'h141414, 1'b0);
		send_pixel(24'h808080, 1'b0);
		send_pixel(24'hAAAAAA, 1'b0);
		send_pixel(24'h555555, 1'b1);
		send_pixel(24'h0000FE, 1'b0);
		send_pixel(24'hFE0000, 1'b0);
		send_pixel(24'h000A00, 1'b0);
		send_pixel(24'h0A00FF, 1'b1);

		// Random: mostly uniform pixels, some built from edge codes, some gray
		for (i = 0; i < N_RANDOM; i++) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				px = 24'($urandom());
			end else if (r < 9) begin
				px = {edge_codes[$urandom_range(0, 5)], edge_codes[$urandom_range(0, 5)],
					edge_codes[$urandom_range(0, 5)]};
			end else begin
				px = {3{8'($urandom_range(0, 255))}};
			end
			send_pixel(px, ($urandom_range(0, 15) == 0));
		end
		pix.valid <= 1'b0;

		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 10) begin
			@(posedge clk);
		end
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[rgb_to_cielab_converter.f]
hdl/rcl_pkg.sv
hdl/rcl_pix_if.sv
hdl/rcl_lab_if.sv
hdl/rcl_linmix.sv
hdl/rcl_fcurve.sv
hdl/rcl_labout.sv
hdl/rgb_to_cielab_converter.sv
dv/rgb_to_cielab_converter_tb.sv
